/* sv/blifo_pkg.sv */
// shared types and constants for the bounded lifo stack
// no dependencies; imported by the controller, datapath and top level
package blifo_pkg;

  // built depth and register reset value
  localparam int DEFAULT_DEPTH = 128;
  localparam int CAP_W = 8;
  localparam logic [CAP_W-1:0] CAP_RESET = 8'd128;

  // field widths
  localparam int ACT_W = 2;
  localparam int WORD_W = 32;
  localparam int STAT_W = 2;
  localparam int OCC_W = 8;

  // word returned by a refused pop or peek
  localparam logic signed [WORD_W-1:0] EMPTY_WORD = 32'sh8000_0000;

  // operation codes; code three acts as a peek
  localparam logic [ACT_W-1:0] ACT_PUSH = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP = 2'd1;
  localparam logic [ACT_W-1:0] ACT_PEEK = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_RESP
  } state_t;

  // kind of result loaded into the output register
  typedef enum logic [1:0] {
    RES_PUSH,
    RES_FULL,
    RES_EMPTY,
    RES_READ
  } res_sel_t;

  // controller to datapath commands
  typedef struct packed {
    logic     latch;
    logic     write_en;
    logic     rd_en;
    logic     dec;
    logic     res_load;
    res_sel_t res_sel;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic full;
    logic empty;
  } sts_t;

endpackage

/* sv/bounded_lifo_stack_top.sv */
// bounded lifo stack: push, pop or peek on signed 32-bit words, one result per request
// a push, a full refusal or an empty refusal loads its result in the execute state; a pop
// or peek that reads an entry passes through a read state before its result is loaded
// (the entry memory read is registered); one request at a time: a new request is taken
// only after the last result has been accepted, so an output stall holds the flow
// reset (rst, synchronous): stack empty, capacity 128; memory contents are not cleared
// depends on blifo_pkg, blifo_ctrl, blifo_dp
module bounded_lifo_stack_top import blifo_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  // capacity register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,  // action[1:0], push_value[33:2], zero pad[39:34]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata   // status[1:0], top_value[33:2], occupancy[41:34], zero[47:42]
);

  cmd_t                     cmd;
  sts_t                     sts;
  logic [STAT_W-1:0]        res_status;
  logic signed [WORD_W-1:0] res_data;
  logic [OCC_W-1:0]         res_occ;

  // configuration is always taken
  assign cfg_ready = 1'b1;

  blifo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  blifo_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_cap    (cfg_data),
    .in_action  (s_tdata[1:0]),
    .in_value   (s_tdata[33:2]),
    .cmd        (cmd),
    .sts        (sts),
    .res_status (res_status),
    .res_data   (res_data),
    .res_occ    (res_occ)
  );

  // result packing
  assign m_tdata = {6'd0, res_occ, res_data, res_status};

endmodule

/* sv/blifo_ctrl.sv */
// controller state machine for the bounded lifo stack
// depends on blifo_pkg; drives the datapath through cmd_t, reads sts_t
module blifo_ctrl import blifo_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_sel = RES_PUSH;
    in_ready = 1'b0;
    out_valid = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.is_push) begin
          cmd.res_load = 1'b1;
          if (sts.full) begin
            cmd.res_sel = RES_FULL;
          end else begin
            cmd.write_en = 1'b1;
            cmd.res_sel = RES_PUSH;
          end
          state_next = S_RESP;
        end else if (sts.empty) begin
          cmd.res_load = 1'b1;
          cmd.res_sel = RES_EMPTY;
          state_next = S_RESP;
        end else begin
          cmd.rd_en = 1'b1;
          state_next = S_READ;
        end
      end
      S_READ: begin
        // read data is registered; pop drops the top now
        cmd.res_load = 1'b1;
        cmd.res_sel = RES_READ;
        cmd.dec = sts.is_pop;
        state_next = S_RESP;
      end
      S_RESP: begin
        out_valid = 1'b1;
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/blifo_dp.sv */
// datapath for the bounded lifo stack: entry memory, count, capacity, result register
// depends on blifo_pkg; commanded by blifo_ctrl
module blifo_dp import blifo_pkg::*; #(
  parameter int STACK_DEPTH = DEFAULT_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CAP_W-1:0]         cfg_cap,
  input  logic [ACT_W-1:0]         in_action,
  input  logic signed [WORD_W-1:0] in_value,
  input  cmd_t                     cmd,
  output sts_t                     sts,
  output logic [STAT_W-1:0]        res_status,
  output logic signed [WORD_W-1:0] res_data,
  output logic [OCC_W-1:0]         res_occ
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int XW = (CW > CAP_W) ? CW : CAP_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);

  logic [ACT_W-1:0]         action;
  logic signed [WORD_W-1:0] value;
  logic [CW-1:0]            count, count_next;
  logic [CAP_W-1:0]         cap;
  logic signed [WORD_W-1:0] mem [STACK_DEPTH];
  logic signed [WORD_W-1:0] rd_data;
  logic [CW-1:0]            top_idx;

  // capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      cap <= CAP_RESET;
    end else if (cfg_we) begin
      cap <= cfg_cap;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      action <= in_action;
      value <= in_value;
    end
  end

  // status toward the controller
  assign top_idx = count - CW'(1);
  always_comb begin
    sts.is_push = (action == ACT_PUSH);
    sts.is_pop = (action == ACT_POP);
    sts.full = (XW'(count) >= XW'(cap)) || (count >= DEPTH_C);
    sts.empty = (count == '0);
  end

  // entry count
  always_comb begin
    count_next = count;
    if (cmd.write_en) begin
      count_next = count + CW'(1);
    end else if (cmd.dec) begin
      count_next = top_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // entry memory, one write or one registered read
  always_ff @(posedge clk) begin
    if (cmd.write_en) begin
      mem[count[AW-1:0]] <= value;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[top_idx[AW-1:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      res_occ <= OCC_W'(count_next);
      case (cmd.res_sel)
        RES_PUSH: begin
          res_status <= ST_OK;
          res_data <= '0;
        end
        RES_FULL: begin
          res_status <= ST_FULL;
          res_data <= '0;
        end
        RES_EMPTY: begin
          res_status <= ST_EMPTY;
          res_data <= EMPTY_WORD;
        end
        RES_READ: begin
          res_status <= ST_OK;
          res_data <= rd_data;
        end
        default: begin
          res_status <= ST_OK;
          res_data <= '0;
        end
      endcase
    end
  end

endmodule
